// File: rtl/bump_allocator_with_block_table_unit_assert.svh
// Assertion macros for the bump allocator unit.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef BUMP_ALLOCATOR_WITH_BLOCK_TABLE_UNIT_ASSERT_SVH
`define BUMP_ALLOCATOR_WITH_BLOCK_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on the rising clock edge.
`define BAT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed in bump allocator unit.");
// Next-cycle implication, checked on the rising clock edge.
`define BAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed in bump allocator unit.");
`else
`define BAT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/bat_pkg.sv
// Package for the bump allocator unit: transfer types, opcodes, status codes
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package bat_pkg;

   // Field widths of the request and response transfers.
   localparam int OP_W    = 2;
   localparam int SIZE_W  = 17;
   localparam int OFFS_W  = 16;
   localparam int STAT_W  = 3;
   localparam int TALLY_W = 7;

   // Opcodes.
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOSPACE  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SIZE_W-1:0] alloc_size;
      logic [OFFS_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [OFFS_W-1:0]  granted_offset;
      logic [SIZE_W-1:0]  bytes_used;
      logic [SIZE_W-1:0]  bytes_free;
      logic [SIZE_W-1:0]  peak_bytes;
      logic [TALLY_W-1:0] allocs_done;
      logic [TALLY_W-1:0] frees_done;
   } rsp_type;

   // Sequencer states: idle, or scanning the block table for a free.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// File: rtl/bat_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port: data read with rd_en appears in the next cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bat_ctrl.sv
// Sequencer and statistics of the bump allocator unit. It drives the block
// table memory and forms each response. Depends on bat_pkg.
`timescale 1ns / 1ps

module bat_ctrl #(
   parameter int HEAP_BYTES    = 65536,
   parameter int TABLE_ENTRIES = 64,
   localparam int PTR_W = $clog2(HEAP_BYTES + 1),
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int ENT_W = 2 * PTR_W + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  bat_pkg::req_type        req,
   output logic                    busy,
   output logic                    rsp_valid,
   output bat_pkg::rsp_type        rsp,
   output logic                    mem_wr_en,
   output logic [IDX_W-1:0]        mem_wr_addr,
   output logic [ENT_W-1:0]        mem_wr_data,
   output logic                    mem_rd_en,
   output logic [IDX_W-1:0]        mem_rd_addr,
   input  logic [ENT_W-1:0]        mem_rd_data
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CW    = ((PTR_W > bat_pkg::SIZE_W) ? PTR_W : bat_pkg::SIZE_W) + 1;
   localparam int MW    = (PTR_W > bat_pkg::OFFS_W) ? PTR_W : bat_pkg::OFFS_W;
   localparam logic [PTR_W-1:0] HEAP_C = PTR_W'(HEAP_BYTES);
   localparam logic [CNT_W-1:0] TBL_C  = CNT_W'(TABLE_ENTRIES);

   bat_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0] bump_ff, bump_in;
   logic [PTR_W-1:0] used_ff, used_in;
   logic [PTR_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0] entries_ff, entries_in;
   logic [CNT_W-1:0] allocs_ff, allocs_in;
   logic [CNT_W-1:0] frees_ff, frees_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [bat_pkg::OFFS_W-1:0] free_off_ff, free_off_in;

   logic                 accept;
   logic [PTR_W-1:0]     remaining;
   logic [CW-1:0]        size_x;
   logic [CW-1:0]        rem_x;
   logic [CW-1:0]        aligned_x;
   logic [PTR_W-1:0]     aligned;
   logic                 rd_live;
   logic [PTR_W-1:0]     rd_off;
   logic [PTR_W-1:0]     rd_size;
   logic                 hit;
   logic                 scan_more;
   logic [bat_pkg::STAT_W-1:0] status;
   logic [PTR_W-1:0]     granted;

   assign accept = start && (state_ff == bat_pkg::ST_IDLE);
   assign busy   = (state_ff != bat_pkg::ST_IDLE);

   // Allocation arithmetic: remaining room and the size rounded up to a word.
   assign remaining = (bump_ff < HEAP_C) ? (HEAP_C - bump_ff) : '0;
   assign size_x    = CW'(req.alloc_size);
   assign rem_x     = CW'(remaining);
   assign aligned_x = (size_x + CW'(3)) & ~CW'(3);
   assign aligned   = aligned_x[PTR_W-1:0];

   // Table entry layout is {live, offset, size}.
   assign rd_live = mem_rd_data[ENT_W-1];
   assign rd_off  = mem_rd_data[2*PTR_W-1:PTR_W];
   assign rd_size = mem_rd_data[PTR_W-1:0];

   // Scan compare: the entry read last cycle matches a live block.
   assign hit       = chk_vld_ff && rd_live && (MW'(rd_off) == MW'(free_off_ff));
   assign scan_more = (scan_ff < entries_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bat_pkg::ST_IDLE: begin
            if (accept && (req.op == bat_pkg::OP_FREE)) begin
               state_in = bat_pkg::ST_SCAN;
            end
         end
         bat_pkg::ST_SCAN: begin
            if (hit || (!scan_more && !chk_vld_ff)) begin
               state_in = bat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bat_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, memory control and response.
   always_comb begin
      bump_in     = bump_ff;
      used_in     = used_ff;
      peak_in     = peak_ff;
      entries_in  = entries_ff;
      allocs_in   = allocs_ff;
      frees_in    = frees_ff;
      scan_in     = scan_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      free_off_in = free_off_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = entries_ff[IDX_W-1:0];
      mem_wr_data = {1'b1, bump_ff, aligned};
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_ff[IDX_W-1:0];
      rsp_valid   = 1'b0;
      status      = bat_pkg::STAT_OK;
      granted     = '0;
      case (state_ff)
         bat_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.op)
                  bat_pkg::OP_ALLOC: begin
                     rsp_valid = 1'b1;
                     if (req.alloc_size == '0) begin
                        status = bat_pkg::STAT_ZERO;
                     end else if (size_x > rem_x) begin
                        status = bat_pkg::STAT_NOSPACE;
                     end else if (entries_ff >= TBL_C) begin
                        status = bat_pkg::STAT_FULL;
                     end else if (aligned_x > rem_x) begin
                        status = bat_pkg::STAT_NOSPACE;
                     end else begin
                        // Record the block and advance the bump pointer.
                        mem_wr_en  = 1'b1;
                        granted    = bump_ff;
                        bump_in    = bump_ff + aligned;
                        used_in    = used_ff + aligned;
                        peak_in    = ((used_ff + aligned) > peak_ff) ?
                                     (used_ff + aligned) : peak_ff;
                        entries_in = entries_ff + CNT_W'(1);
                        allocs_in  = allocs_ff + CNT_W'(1);
                     end
                  end
                  bat_pkg::OP_FREE: begin
                     free_off_in = req.free_offset;
                     scan_in     = '0;
                  end
                  bat_pkg::OP_CLEAR: begin
                     rsp_valid  = 1'b1;
                     bump_in    = '0;
                     used_in    = '0;
                     peak_in    = '0;
                     entries_in = '0;
                     allocs_in  = '0;
                     frees_in   = '0;
                  end
                  default: begin
                     rsp_valid = 1'b1;
                  end
               endcase
            end
         end
         bat_pkg::ST_SCAN: begin
            if (hit) begin
               // Retire the block: clear its live bit in place.
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_idx_ff;
               mem_wr_data = {1'b0, rd_off, rd_size};
               used_in     = used_ff - rd_size;
               frees_in    = frees_ff + CNT_W'(1);
               rsp_valid   = 1'b1;
            end else if (scan_more) begin
               // Issue the read of the next entry; it is compared next cycle.
               mem_rd_en  = 1'b1;
               scan_in    = scan_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
            end else if (!chk_vld_ff) begin
               rsp_valid = 1'b1;
               status    = bat_pkg::STAT_NOTFOUND;
            end
         end
         default: begin
         end
      endcase

      rsp.status         = status;
      rsp.granted_offset = bat_pkg::OFFS_W'(granted);
      rsp.bytes_used     = bat_pkg::SIZE_W'(used_in);
      rsp.bytes_free     = bat_pkg::SIZE_W'(HEAP_C - used_in);
      rsp.peak_bytes     = bat_pkg::SIZE_W'(peak_in);
      rsp.allocs_done    = bat_pkg::TALLY_W'(allocs_in);
      rsp.frees_done     = bat_pkg::TALLY_W'(frees_in);
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bat_pkg::ST_IDLE;
         bump_ff    <= '0;
         used_ff    <= '0;
         peak_ff    <= '0;
         entries_ff <= '0;
         allocs_ff  <= '0;
         frees_ff   <= '0;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bump_ff    <= bump_in;
         used_ff    <= used_in;
         peak_ff    <= peak_in;
         entries_ff <= entries_in;
         allocs_ff  <= allocs_in;
         frees_ff   <= frees_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   // Payload registers of the scan.
   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      free_off_ff <= free_off_in;
   end

endmodule

// File: rtl/bump_allocator_with_block_table_unit.sv
// Allocate, clear and no-op: result strobed in the cycle after the start transfer, busy stays low.
// Free: the scan reads one table entry per cycle from entry 0 up to the fill count, stopping at
// the first live block at the requested offset; if none matches, the result reports not found.
// Results come at most one per cycle and the receiver cannot stall them.
// Reset is synchronous; the table needs no clearing pass, as only entries below the
// fill count are ever read. Top level; depends on bat_pkg, bat_ram, bat_ctrl and the macros.
`timescale 1ns / 1ps
`include "bump_allocator_with_block_table_unit_assert.svh"

module bump_allocator_with_block_table_unit #(
   parameter int HEAP_BYTES    = 65536,
   parameter int TABLE_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bat_pkg::req_type req_item,
   output logic             rsp_strobe,
   output bat_pkg::rsp_type rsp_item
);

   localparam int PTR_W = $clog2(HEAP_BYTES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENT_W = 2 * PTR_W + 1;
   localparam logic [bat_pkg::SIZE_W-1:0] HEAP_LOW = bat_pkg::SIZE_W'(HEAP_BYTES);

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [ENT_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [ENT_W-1:0] mem_rd_data;
   logic             rsp_valid;
   bat_pkg::rsp_type rsp;

   logic             rsp_valid_ff;
   bat_pkg::rsp_type rsp_ff;
   logic [bat_pkg::SIZE_W-1:0] balance;

   // Block table: {live, offset, size} per entry.
   bat_ram #(
      .WIDTH(ENT_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // Sequencer and statistics.
   bat_ctrl #(
      .HEAP_BYTES   (HEAP_BYTES),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_item),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   // Output register: each result is shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // Used plus free bytes always make up the heap, modulo the field width.
   assign balance = rsp_ff.bytes_used + rsp_ff.bytes_free;

   // Every transfer other than a free answers in the next cycle.
   `BAT_ASSERT_NEXT(a_quick_ops_answer, clock, reset,
      start && !busy && (req_item.op != bat_pkg::OP_FREE), rsp_strobe)
   // No result is shown while a table scan is still running.
   `BAT_ASSERT_IMPLY(a_no_result_while_busy, clock, reset, busy, !rsp_strobe)
   // The usage figures of every result are consistent with the heap size.
   `BAT_ASSERT_IMPLY(a_balance, clock, reset, rsp_strobe, balance == HEAP_LOW)
   // A failed request grants nothing.
   `BAT_ASSERT_IMPLY(a_no_grant_on_error, clock, reset,
      rsp_strobe && (rsp_item.status != bat_pkg::STAT_OK), rsp_item.granted_offset == '0)

endmodule
